// File: hw/rtl/epwc_pkg.sv
// Shared constants and types for the edge pulse width capture block.
`timescale 1ns / 1ps

package epwc_pkg;

	localparam int MAX_PULSES = 512;
	localparam int CNT_W      = $clog2(MAX_PULSES + 1);
	localparam int IDX_W      = 9;
	localparam int TOTAL_W    = 10;
	localparam int DUR_W      = 16;
	localparam int GAP_W      = 20;
	localparam int TMO_MS_W   = 16;
	localparam int US_PER_MS  = 1000;
	localparam int MS_MUL_W   = 10;

	// Largest timeout in microseconds fits in this many bits; the timers never pass it.
	localparam int TIMER_W    = $clog2(((2 ** TMO_MS_W) - 1) * US_PER_MS + 2);

	localparam logic [DUR_W-1:0]   DUR_SAT    = 16'hFFFF;
	localparam logic [CNT_W-1:0]   CNT_MAX    = CNT_W'(MAX_PULSES);
	localparam logic [GAP_W-1:0]   GAP_RESET  = 20'd10000;
	localparam logic [TIMER_W-1:0] TMO_RESET  = TIMER_W'(5000 * US_PER_MS);

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 20;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 40;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_END_GAP = 1'b0,
		CFG_TIMEOUT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		REASON_NONE    = 2'd0,
		REASON_GAP     = 2'd1,
		REASON_FULL    = 2'd2,
		REASON_TIMEOUT = 2'd3
	} end_reason_t;

	typedef enum logic {
		ACT_TICK  = 1'b0,
		ACT_START = 1'b1
	} action_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] pulse_total;
		end_reason_t        end_reason;
		logic [IDX_W-1:0]   pulse_index;
		logic [DUR_W-1:0]   duration_us;
	} result_t;

endpackage

// File: hw/rtl/edge_pulse_width_capture_top.sv
// Top level of the edge pulse width capture block.
//
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tuser: action; tdata: level
// m_axis    out        m_axis_tvalid/m_axis_tready  tuser: has_duration; tlast: is_end;
//                                                   tdata: duration, index, reason, total
// cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// One item is taken every cycle while the output is not stalled; each item passes through
// the input register, and its result, if any, is registered in the output register.
// The timer, edge and end checks are one increment and compare stage between them.
// A stalled output holds the result, and the input register then fills and holds.
// Reset returns the block to idle with the default gap and timeout.
`timescale 1ns / 1ps

module edge_pulse_width_capture_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [epwc_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [0] level
	input  logic                               s_axis_tuser,  // [0] action
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [epwc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // [15:0] duration_us,
	                                                          // [24:16] pulse_index,
	                                                          // [26:25] end_reason,
	                                                          // [36:27] pulse_total
	output logic                               m_axis_tuser,  // [0] has_duration
	output logic                               m_axis_tlast,  // is_end
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [epwc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [epwc_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import epwc_pkg::*;

	logic [GAP_W-1:0]   end_gap_q;
	logic [TIMER_W-1:0] timeout_us_q;

	logic               valid_s1;
	action_t            action_s1;
	logic               level_s1;

	logic               capturing_q;
	logic               prev_level_q;
	logic [TIMER_W-1:0] since_edge_q;
	logic [TIMER_W-1:0] elapsed_q;
	logic [CNT_W-1:0]   count_q;

	logic               out_valid_q;
	logic               has_dur_q;
	logic               is_end_q;
	result_t            result_q;

	logic               advance;
	logic               is_tick;
	logic               edge_seen;
	logic               stored;
	logic [TIMER_W-1:0] since_inc;
	logic [TIMER_W-1:0] since_next;
	logic [TIMER_W-1:0] elapsed_inc;
	logic [CNT_W-1:0]   count_next;
	logic [DUR_W-1:0]   dur;
	end_reason_t        reason;
	logic               emit;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	assign is_tick     = (action_s1 == ACT_TICK) && capturing_q;
	assign since_inc   = since_edge_q + TIMER_W'(1);
	assign elapsed_inc = elapsed_q + TIMER_W'(1);
	assign edge_seen   = level_s1 != prev_level_q;
	assign stored      = edge_seen && (count_q < CNT_MAX);
	assign count_next  = count_q + CNT_W'(stored);
	assign since_next  = edge_seen ? '0 : since_inc;
	assign dur         = (since_inc > TIMER_W'(DUR_SAT)) ? DUR_SAT : since_inc[DUR_W-1:0];

	always_comb begin
		priority if (elapsed_inc >= timeout_us_q) begin
			reason = REASON_TIMEOUT;
		end else if ((count_next != '0) && (since_next > TIMER_W'(end_gap_q))) begin
			reason = REASON_GAP;
		end else if (count_next >= CNT_MAX) begin
			reason = REASON_FULL;
		end else begin
			reason = REASON_NONE;
		end
	end

	assign emit = is_tick && (stored || (reason != REASON_NONE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_gap_q    <= GAP_RESET;
			timeout_us_q <= TMO_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_END_GAP: end_gap_q <= cfg_data[GAP_W-1:0];
				CFG_TIMEOUT: timeout_us_q <= TIMER_W'(cfg_data[TMO_MS_W-1:0])
					* TIMER_W'(MS_MUL_W'(US_PER_MS));
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			action_s1 <= action_t'(s_axis_tuser);
			level_s1  <= s_axis_tdata[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capturing_q  <= 1'b0;
			prev_level_q <= 1'b0;
			since_edge_q <= '0;
			elapsed_q    <= '0;
			count_q      <= '0;
		end else if (advance) begin
			if (action_s1 == ACT_START) begin
				capturing_q  <= 1'b1;
				prev_level_q <= level_s1;
				since_edge_q <= '0;
				elapsed_q    <= '0;
				count_q      <= '0;
			end else if (capturing_q) begin
				prev_level_q <= level_s1;
				since_edge_q <= since_next;
				elapsed_q    <= elapsed_inc;
				count_q      <= count_next;
				if (reason != REASON_NONE) begin
					capturing_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			has_dur_q            <= stored;
			is_end_q             <= reason != REASON_NONE;
			result_q.duration_us <= stored ? dur : '0;
			result_q.pulse_index <= stored ? count_q[IDX_W-1:0] : '0;
			result_q.end_reason  <= reason;
			result_q.pulse_total <= TOTAL_W'(count_next);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = has_dur_q;
	assign m_axis_tlast  = is_end_q;
	assign m_axis_tdata  = OUT_DATA_W'(result_q);

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("captured count passed the buffer size");

	a_end_has_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (is_end_q == (result_q.end_reason != REASON_NONE)))
		else $error("end flag and end reason disagree");

	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !has_dur_q) |-> is_end_q)
		else $error("result with neither a segment nor an end");

	a_index_total: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && has_dur_q)
		|-> (result_q.pulse_total == TOTAL_W'(result_q.pulse_index) + TOTAL_W'(1)))
		else $error("segment index does not match the running total");

	a_idle_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit && (reason != REASON_NONE)) |=> !capturing_q)
		else $error("capture still armed after an end result");

endmodule
